[src/ffra_pkg.sv]
// Shared types and constants for the first-fit range allocator.
// Holds the request/result payload structs, the range entry type and status codes.
// No dependencies.
package ffra_pkg;

  localparam int unsigned POOL_BITS = 16;
  localparam int unsigned VAL_W     = POOL_BITS + 1;

  localparam logic [VAL_W-1:0] POOL_MAX  = VAL_W'(1) << POOL_BITS;
  localparam logic [VAL_W-1:0] WIDE_MAX  = '1;

  // Register index of pool_capacity on the configuration port.
  localparam logic REG_POOL_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_NO_SPACE   = 2'd1,
    STATUS_TABLE_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] last;
  } range_t;

  typedef struct packed {
    logic                   kind;
    logic [POOL_BITS-1:0]   block_start;
    logic [VAL_W-1:0]       block_length;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [VAL_W-1:0]       granted_start;
    logic [VAL_W-1:0]       granted_end;
    logic [VAL_W-1:0]       reserved_total;
  } rsp_t;

endpackage

[src/ffra_table.sv]
// Range table memory: one write port, one registered read port.
// Entry 0 reads as [0, capacity) after reset or a capacity write until it is written.
// Depends on ffra_pkg.
module ffra_table import ffra_pkg::*; #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          init_i,
  input  logic [VAL_W-1:0]              cap_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_RANGES)-1:0] rd_addr_i,
  output range_t                        rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_RANGES)-1:0] wr_addr_i,
  input  range_t                        wr_data_i
);

  localparam int unsigned AW = $clog2(MAX_RANGES);

  range_t mem [MAX_RANGES];
  range_t rdata_q;
  logic   fresh_q;
  logic   rd_fresh_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // The fresh flag stands in for entry 0 of a newly initialized table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= 1'b1;
      rd_fresh_q <= 1'b0;
    end else begin
      if (init_i) begin
        fresh_q <= 1'b1;
      end else if (wr_en_i && wr_addr_i == AW'(0)) begin
        fresh_q <= 1'b0;
      end
      if (rd_en_i) begin
        rd_fresh_q <= fresh_q && rd_addr_i == AW'(0);
      end
    end
  end

  always_comb begin
    if (rd_fresh_q) begin
      rd_data_o.first = '0;
      rd_data_o.last  = cap_i;
    end else begin
      rd_data_o = rdata_q;
    end
  end

endmodule

[src/first_fit_range_allocator.sv]
// First-fit range allocator: top level with request sequencer and configuration port.
// Depends on ffra_pkg and ffra_table.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+---------------------------------
//   request   | start (in), busy (out)      | req_i  (kind, block_start, block_length)
//   result    | done_o strobe, one cycle    | rsp_o  (status, granted_start/end, reserved_total)
//   config    | APB psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// An allocate scans the stored ranges; a free scans them, then compacts the table and flushes
// the pending entry. The scan and the compaction each walk the table one entry per cycle,
// as the range memory has a single read port.
// Reset gives one free range [0, 65536) and a reserved total of zero.
// The result strobe follows the last cycle of work; the receiver cannot stall it.
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_COMPACT = 2'd2;
  localparam logic [1:0] S_FLUSH   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [VAL_W-1:0] cap_q, cap_d;
  logic [CW-1:0]    count_q, count_d;
  logic [VAL_W-1:0] reserved_q, reserved_d;
  logic             kind_q, kind_d;
  logic [VAL_W-1:0] len_q, len_d;
  logic [VAL_W-1:0] start_q, start_d;
  logic [VAL_W-1:0] end_q, end_d;
  logic [CW-1:0]    ri_q, ri_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    ev_idx_q, ev_idx_d;
  logic             ins_q, ins_d;
  logic             full_q, full_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    vcount_q, vcount_d;
  logic             cins_q, cins_d;
  logic             have_q, have_d;
  logic [VAL_W-1:0] pf_q, pf_d;
  logic [VAL_W-1:0] pl_q, pl_d;
  logic [CW-1:0]    wr_q, wr_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             tbl_init;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  range_t           rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  range_t           wr_data;

  logic             cfg_write;
  logic [VAL_W-1:0] cfg_cap;

  assign pready    = 1'b1;
  assign busy      = state_q != S_IDLE;
  assign done_o    = done_q;
  assign rsp_o     = rsp_q;
  assign cfg_write = psel && penable && pwrite && paddr[2] == REG_POOL_CAPACITY;
  assign cfg_cap   = (pwdata[VAL_W-1:0] > POOL_MAX) ? POOL_MAX : pwdata[VAL_W-1:0];
  assign tbl_init  = cfg_write;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_POOL_CAPACITY) begin
      prdata = {{(32 - VAL_W){1'b0}}, cap_q};
    end
  end

  ffra_table #(
    .MAX_RANGES (MAX_RANGES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (tbl_init),
    .cap_i     (cap_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_comb begin
    logic [VAL_W:0]   sum_end;
    logic [VAL_W:0]   sum_res;
    logic [VAL_W-1:0] freed;
    logic [VAL_W-1:0] ge;
    range_t           item;
    logic             issue;
    logic             alloc_fit;
    logic             ext_last;
    logic             ext_first;
    logic             before_hit;
    logic             hit;
    logic             ins_need;
    logic             is_ins;
    logic [CW-1:0]    phys;

    state_d    = state_q;
    cap_d      = cap_q;
    count_d    = count_q;
    reserved_d = reserved_q;
    kind_d     = kind_q;
    len_d      = len_q;
    start_d    = start_q;
    end_d      = end_q;
    ri_d       = ri_q;
    rv_d       = rv_q;
    ev_idx_d   = ev_idx_q;
    ins_d      = ins_q;
    full_d     = full_q;
    pos_d      = pos_q;
    vcount_d   = vcount_q;
    cins_d     = cins_q;
    have_d     = have_q;
    pf_d       = pf_q;
    pl_d       = pl_q;
    wr_d       = wr_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;

    sum_end    = {1'b0, {(VAL_W - POOL_BITS){1'b0}}, req_i.block_start}
                 + {1'b0, req_i.block_length};
    item       = cins_q ? range_t'{first: start_q, last: end_q} : rd_data;
    ge         = item.first + len_q;
    sum_res    = {1'b0, reserved_q} + {1'b0, len_q};
    freed      = end_q - start_q;
    issue      = 1'b0;
    is_ins     = 1'b0;
    phys       = ri_q;
    alloc_fit  = item.last >= item.first && len_q <= item.last - item.first;
    ext_last   = start_q == item.last;
    ext_first  = end_q == item.first;
    before_hit = end_q < item.first;
    hit        = rv_q && (kind_q ? (ext_last || ext_first || before_hit) : alloc_fit);
    ins_need   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cfg_write) begin
          cap_d      = cfg_cap;
          count_d    = CW'(1);
          reserved_d = '0;
        end
        if (start) begin
          kind_d  = req_i.kind;
          len_d   = req_i.block_length;
          start_d = ({1'b0, req_i.block_start} > cap_q) ? cap_q
                                                         : {1'b0, req_i.block_start};
          end_d   = (sum_end > {1'b0, cap_q}) ? cap_q : sum_end[VAL_W-1:0];
          ri_d    = '0;
          rv_d    = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        issue = ri_q < count_q;
        if (issue) begin
          rd_en    = 1'b1;
          rd_addr  = ri_q[AW-1:0];
          ri_d     = ri_q + CW'(1);
          ev_idx_d = ri_q[AW-1:0];
        end
        rv_d = issue;
        if (!kind_q) begin
          if (hit) begin
            wr_en                = 1'b1;
            wr_addr              = ev_idx_q;
            wr_data              = '{first: ge, last: item.last};
            reserved_d           = sum_res[VAL_W] ? WIDE_MAX : sum_res[VAL_W-1:0];
            rsp_d.status         = STATUS_DONE;
            rsp_d.granted_start  = item.first;
            rsp_d.granted_end    = ge;
            rsp_d.reserved_total = sum_res[VAL_W] ? WIDE_MAX : sum_res[VAL_W-1:0];
            done_d               = 1'b1;
            state_d              = S_IDLE;
          end else if (!issue) begin
            rsp_d.status         = STATUS_NO_SPACE;
            rsp_d.granted_start  = '0;
            rsp_d.granted_end    = '0;
            rsp_d.reserved_total = reserved_q;
            done_d               = 1'b1;
            state_d              = S_IDLE;
          end
        end else if (hit || !issue) begin
          // Extensions are written in place; an insertion is merged in by the compaction.
          if (hit && ext_last) begin
            wr_en   = 1'b1;
            wr_addr = ev_idx_q;
            wr_data = '{first: item.first, last: end_q};
          end else if (hit && ext_first) begin
            wr_en   = 1'b1;
            wr_addr = ev_idx_q;
            wr_data = '{first: start_q, last: item.last};
          end else begin
            ins_need = 1'b1;
          end
          pos_d    = hit ? {{(CW - AW){1'b0}}, ev_idx_q} : count_q;
          full_d   = ins_need && count_q >= CW'(MAX_RANGES);
          ins_d    = ins_need && count_q < CW'(MAX_RANGES);
          vcount_d = (ins_need && count_q < CW'(MAX_RANGES)) ? count_q + CW'(1) : count_q;
          ri_d     = '0;
          rv_d     = 1'b0;
          cins_d   = 1'b0;
          have_d   = 1'b0;
          wr_d     = '0;
          state_d  = S_COMPACT;
        end
      end

      S_COMPACT: begin
        issue = ri_q < vcount_q;
        if (issue) begin
          is_ins = ins_q && ri_q == pos_q;
          phys   = (ins_q && ri_q > pos_q) ? ri_q - CW'(1) : ri_q;
          rd_en  = !is_ins;
          rd_addr = phys[AW-1:0];
          ri_d   = ri_q + CW'(1);
        end
        rv_d   = issue;
        cins_d = is_ins;
        if (rv_q && item.first != item.last) begin
          if (have_q && pl_q == item.first) begin
            pl_d = item.last;
          end else begin
            // The pending entry always lands below the next table read.
            if (have_q) begin
              wr_en   = 1'b1;
              wr_addr = AW'(wr_q - CW'(1));
              wr_data = '{first: pf_q, last: pl_q};
            end
            pf_d   = item.first;
            pl_d   = item.last;
            wr_d   = wr_q + CW'(1);
            have_d = 1'b1;
          end
        end
        if (!rv_q && !issue) begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (have_q) begin
          wr_en   = 1'b1;
          wr_addr = AW'(wr_q - CW'(1));
          wr_data = '{first: pf_q, last: pl_q};
        end
        count_d = wr_q;
        if (!full_q) begin
          reserved_d = (reserved_q > freed) ? reserved_q - freed : '0;
        end
        rsp_d.status         = full_q ? STATUS_TABLE_FULL : STATUS_DONE;
        rsp_d.granted_start  = '0;
        rsp_d.granted_end    = '0;
        rsp_d.reserved_total = full_q ? reserved_q
                               : ((reserved_q > freed) ? reserved_q - freed : '0);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cap_q      <= POOL_MAX;
      count_q    <= CW'(1);
      reserved_q <= '0;
      ri_q       <= '0;
      rv_q       <= 1'b0;
      ins_q      <= 1'b0;
      full_q     <= 1'b0;
      cins_q     <= 1'b0;
      have_q     <= 1'b0;
      wr_q       <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cap_q      <= cap_d;
      count_q    <= count_d;
      reserved_q <= reserved_d;
      ri_q       <= ri_d;
      rv_q       <= rv_d;
      ins_q      <= ins_d;
      full_q     <= full_d;
      cins_q     <= cins_d;
      have_q     <= have_d;
      wr_q       <= wr_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    len_q    <= len_d;
    start_q  <= start_d;
    end_q    <= end_d;
    ev_idx_q <= ev_idx_d;
    pos_q    <= pos_d;
    vcount_q <= vcount_d;
    pf_q     <= pf_d;
    pl_q     <= pl_d;
    rsp_q    <= rsp_d;
  end

endmodule
